FILE: hw/rtl/ldr_pkg.sv
// Shared types and constants for the LED dimmer ramp channel.
// No dependencies; every other file imports this package.
package ldr_pkg;

    localparam int LevelW   = 8;
    localparam int MsW      = 24;
    localparam int OpW      = 3;
    localparam int StepW    = 3;
    localparam int CfgAddrW = 5;
    localparam int CfgDataW = 32;
    localparam int CfgIdxW  = 3;

    localparam logic [MsW-1:0] MS_MAX = {MsW{1'b1}};

    // operation codes of an input request
    localparam logic [OpW-1:0] OP_TICK      = 3'd0;
    localparam logic [OpW-1:0] OP_SWITCH    = 3'd1;
    localparam logic [OpW-1:0] OP_ABSOLUTE  = 3'd2;
    localparam logic [OpW-1:0] OP_RELATIVE  = 3'd3;
    localparam logic [OpW-1:0] OP_DAY_NIGHT = 3'd4;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_DAY_LEVEL       = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_USE_DAY_LEVEL   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_NIGHT_LEVEL     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_USE_NIGHT_LEVEL = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_ABSOLUTE_RAMP   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_RELATIVE_RAMP   = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_MIN_LEVEL       = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_MAX_LEVEL       = 3'd7;

    typedef enum logic [2:0] {
        TASK_IDLE = 3'd0,
        TASK_STOP = 3'd1,
        TASK_ON   = 3'd2,
        TASK_OFF  = 3'd3,
        TASK_SET  = 3'd4,
        TASK_UP   = 3'd5,
        TASK_DOWN = 3'd6
    } t_task;

    typedef struct packed {
        logic [LevelW-1:0] day_level;
        logic              use_day_level;
        logic [LevelW-1:0] night_level;
        logic              use_night_level;
        logic [MsW-1:0]    absolute_ramp_ms;
        logic [MsW-1:0]    relative_ramp_ms;
        logic [LevelW-1:0] min_level;
        logic [LevelW-1:0] max_level;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic exec;
        logic div_start;
        logic load_interval;
        logic step_commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic need_div;
        logic div_done;
        logic has_result;
        logic out_busy;
    } t_stat;

endpackage

FILE: hw/rtl/ldr_in_if.sv
// Input request channel of the dimmer channel: valid/ready plus command fields.
// Depends on ldr_pkg for field widths.
interface ldr_in_if import ldr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OpW-1:0]    operation;
    logic              switch_on;
    logic [LevelW-1:0] level;
    logic              direction;
    logic [StepW-1:0]  step_code;
    logic              night;

    modport source (
        output valid, operation, switch_on, level, direction, step_code, night,
        input  ready
    );
    modport sink (
        input  valid, operation, switch_on, level, direction, step_code, night,
        output ready
    );
endinterface

FILE: hw/rtl/ldr_out_if.sv
// Result channel of the dimmer channel: valid/ready plus drive level or status.
// Depends on ldr_pkg for field widths.
interface ldr_out_if import ldr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              report_kind;
    logic [LevelW-1:0] current_level;
    logic              is_on;
    logic              on_changed;

    modport source (
        output valid, report_kind, current_level, is_on, on_changed,
        input  ready
    );
    modport sink (
        input  valid, report_kind, current_level, is_on, on_changed,
        output ready
    );
endinterface

FILE: hw/rtl/ldr_cfg_regs.sv
// APB-style configuration register file of the dimmer channel.
// Depends on ldr_pkg (t_cfg, register indexes).
module ldr_cfg_regs import ldr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [CfgDataW-1:0] pwdata,
    output logic [CfgDataW-1:0] prdata,
    output logic                pready,
    output t_cfg                o_cfg
);

    t_cfg               r_cfg;
    logic [CfgIdxW-1:0] idx;
    logic               wr_en;

    assign idx    = paddr[CfgAddrW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.day_level        <= 8'd255;
            r_cfg.use_day_level    <= 1'b1;
            r_cfg.night_level      <= 8'd26;
            r_cfg.use_night_level  <= 1'b1;
            r_cfg.absolute_ramp_ms <= 24'd1000;
            r_cfg.relative_ramp_ms <= 24'd5000;
            r_cfg.min_level        <= 8'd0;
            r_cfg.max_level        <= 8'd255;
        end else if (wr_en) begin
            case (idx)
                REG_DAY_LEVEL:       r_cfg.day_level        <= pwdata[LevelW-1:0];
                REG_USE_DAY_LEVEL:   r_cfg.use_day_level    <= pwdata[0];
                REG_NIGHT_LEVEL:     r_cfg.night_level      <= pwdata[LevelW-1:0];
                REG_USE_NIGHT_LEVEL: r_cfg.use_night_level  <= pwdata[0];
                REG_ABSOLUTE_RAMP:   r_cfg.absolute_ramp_ms <= pwdata[MsW-1:0];
                REG_RELATIVE_RAMP:   r_cfg.relative_ramp_ms <= pwdata[MsW-1:0];
                REG_MIN_LEVEL:       r_cfg.min_level        <= pwdata[LevelW-1:0];
                REG_MAX_LEVEL:       r_cfg.max_level        <= pwdata[LevelW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            REG_DAY_LEVEL:       prdata[LevelW-1:0] = r_cfg.day_level;
            REG_USE_DAY_LEVEL:   prdata[0]          = r_cfg.use_day_level;
            REG_NIGHT_LEVEL:     prdata[LevelW-1:0] = r_cfg.night_level;
            REG_USE_NIGHT_LEVEL: prdata[0]          = r_cfg.use_night_level;
            REG_ABSOLUTE_RAMP:   prdata[MsW-1:0]    = r_cfg.absolute_ramp_ms;
            REG_RELATIVE_RAMP:   prdata[MsW-1:0]    = r_cfg.relative_ramp_ms;
            REG_MIN_LEVEL:       prdata[LevelW-1:0] = r_cfg.min_level;
            REG_MAX_LEVEL:       prdata[LevelW-1:0] = r_cfg.max_level;
            default:             prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/ldr_div.sv
// Serial restoring divider: ramp duration / level distance, one quotient bit a cycle.
// Depends on ldr_pkg for widths.
module ldr_div import ldr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MsW-1:0]    i_dividend,
    input  logic [LevelW-1:0] i_divisor,
    output logic              o_done,
    output logic [MsW-1:0]    o_quotient
);

    localparam int CntW = $clog2(MsW);

    logic              r_busy;
    logic              r_done;
    logic [CntW-1:0]   r_cnt;
    logic [MsW-1:0]    r_quo;
    logic [LevelW-1:0] r_rem;
    logic [LevelW-1:0] r_dvs;

    logic [LevelW:0]   rem_sh;
    logic              q_bit;
    logic [LevelW:0]   rem_sub;

    // shift the next dividend bit into the partial remainder
    assign rem_sh  = {r_rem, r_quo[MsW-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_dvs});
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(MsW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[MsW-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[LevelW-1:0] : rem_sh[LevelW-1:0];
        end
    end

endmodule

FILE: hw/rtl/ldr_dpath.sv
// Datapath of the dimmer channel: level and task state, ramp timing, result register.
// Depends on ldr_pkg and ldr_div.
module ldr_dpath import ldr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [OpW-1:0]    i_operation,
    input  logic              i_switch_on,
    input  logic [LevelW-1:0] i_level,
    input  logic              i_direction,
    input  logic [StepW-1:0]  i_step_code,
    input  logic              i_night,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_report_kind,
    output logic [LevelW-1:0] o_current_level,
    output logic              o_is_on,
    output logic              o_on_changed
);

    // latched request
    logic [OpW-1:0]    r_op;
    logic              r_switch_on;
    logic [LevelW-1:0] r_level;
    logic              r_direction;
    logic [StepW-1:0]  r_step_code;
    logic              r_night;

    // channel state
    logic [LevelW-1:0] r_level_now;
    logic [LevelW-1:0] r_target;
    t_task             r_task;
    logic              r_ramp_started;
    logic [MsW-1:0]    r_interval;
    logic [MsW-1:0]    r_elapsed;
    logic [LevelW-1:0] r_last_day;
    logic [LevelW-1:0] r_last_night;
    logic              r_night_mode;
    logic              r_reported_on;

    // result register
    logic              r_out_valid;
    logic              r_out_kind;
    logic [LevelW-1:0] r_out_level;
    logic              r_out_on;
    logic              r_out_changed;

    logic [LevelW-1:0] goal;
    logic [LevelW-1:0] level_gap;
    logic [MsW-1:0]    dur;
    logic              is_ramp;
    logic              at_goal;
    logic              can_up;
    logic              can_dn;
    logic              step_due;
    logic              on_now;
    logic              has_result;
    logic [LevelW-1:0] new_level;
    logic [LevelW-1:0] on_target;
    logic              div_done;
    logic [MsW-1:0]    quotient;

    always_comb begin
        case (r_task)
            TASK_ON, TASK_SET: goal = r_target;
            TASK_UP:           goal = i_cfg.max_level;
            default:           goal = i_cfg.min_level;
        endcase
    end

    assign is_ramp  = r_task inside {TASK_ON, TASK_SET, TASK_OFF, TASK_UP, TASK_DOWN};
    assign at_goal  = (r_level_now == goal);
    assign level_gap = (r_level_now > goal) ? (r_level_now - goal) : (goal - r_level_now);
    assign dur      = (r_task == TASK_UP || r_task == TASK_DOWN) ? i_cfg.relative_ramp_ms
                                                                 : i_cfg.absolute_ramp_ms;
    assign can_up   = (r_level_now < goal) && (r_level_now < i_cfg.max_level);
    assign can_dn   = (r_level_now > goal) && (r_level_now > i_cfg.min_level);
    assign step_due = (r_elapsed >= r_interval);
    assign on_now   = (r_level_now != '0);
    assign new_level = can_up ? (r_level_now + 1'b1) : (r_level_now - 1'b1);

    assign has_result = (r_task == TASK_STOP) ||
                        (is_ramp && !at_goal && step_due && (can_up || can_dn));

    always_comb begin
        if (r_night_mode) begin
            on_target = i_cfg.use_night_level ? i_cfg.night_level : r_last_night;
        end else begin
            on_target = i_cfg.use_day_level ? i_cfg.day_level : r_last_day;
        end
    end

    ldr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dur),
        .i_divisor  (level_gap),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign o_stat.is_tick    = (r_op == OP_TICK);
    assign o_stat.need_div   = is_ramp && !at_goal && !r_ramp_started;
    assign o_stat.div_done   = div_done;
    assign o_stat.has_result = has_result;
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op        <= i_operation;
            r_switch_on <= i_switch_on;
            r_level     <= i_level;
            r_direction <= i_direction;
            r_step_code <= i_step_code;
            r_night     <= i_night;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_now    <= '0;
            r_target       <= '0;
            r_task         <= TASK_IDLE;
            r_ramp_started <= 1'b0;
            r_interval     <= '0;
            r_elapsed      <= '0;
            r_last_day     <= '0;
            r_last_night   <= '0;
            r_night_mode   <= 1'b0;
            r_reported_on  <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            // a new result may replace the one taken at this edge
            if (i_cmd.step_commit && has_result) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.exec) begin
                case (r_op)
                    OP_TICK: begin
                        if (r_elapsed != MS_MAX) begin
                            r_elapsed <= r_elapsed + 1'b1;
                        end
                    end
                    OP_SWITCH: begin
                        r_ramp_started <= 1'b0;
                        if (r_switch_on) begin
                            r_target <= on_target;
                            r_task   <= TASK_ON;
                        end else begin
                            if (r_night_mode) begin
                                r_last_night <= r_level_now;
                            end else begin
                                r_last_day <= r_level_now;
                            end
                            r_task <= TASK_OFF;
                        end
                    end
                    OP_ABSOLUTE: begin
                        r_target       <= r_level;
                        r_task         <= TASK_SET;
                        r_ramp_started <= 1'b0;
                    end
                    OP_RELATIVE: begin
                        r_ramp_started <= 1'b0;
                        if (r_step_code == '0) begin
                            r_task <= TASK_STOP;
                        end else if (r_direction) begin
                            r_task <= TASK_UP;
                        end else begin
                            r_task <= TASK_DOWN;
                        end
                    end
                    OP_DAY_NIGHT: begin
                        r_night_mode <= r_night;
                    end
                    default: ;
                endcase
            end

            if (i_cmd.load_interval) begin
                r_interval <= quotient;
            end

            if (i_cmd.step_commit) begin
                if (r_task == TASK_STOP) begin
                    r_task         <= TASK_IDLE;
                    r_ramp_started <= 1'b0;
                    r_reported_on  <= on_now;
                end else if (is_ramp) begin
                    if (at_goal) begin
                        r_task         <= TASK_STOP;
                        r_ramp_started <= 1'b0;
                    end else if (step_due) begin
                        if (can_up || can_dn) begin
                            r_level_now    <= new_level;
                            r_ramp_started <= 1'b1;
                            r_elapsed      <= '0;
                        end else begin
                            // limit reached before the target
                            r_task         <= TASK_STOP;
                            r_ramp_started <= 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_commit && has_result) begin
            if (r_task == TASK_STOP) begin
                r_out_kind    <= 1'b1;
                r_out_level   <= r_level_now;
                r_out_on      <= on_now;
                r_out_changed <= (on_now != r_reported_on);
            end else begin
                r_out_kind    <= 1'b0;
                r_out_level   <= new_level;
                r_out_on      <= (new_level != '0);
                r_out_changed <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_report_kind   = r_out_kind;
    assign o_current_level = r_out_level;
    assign o_is_on         = r_out_on;
    assign o_on_changed    = r_out_changed;

endmodule

FILE: hw/rtl/ldr_ctrl.sv
// Sequencer of the dimmer channel: accept, execute, divide, step, and result hand-off.
// Depends on ldr_pkg (t_cmd, t_stat).
module ldr_ctrl import ldr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_STEP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;

    assign o_in_ready = r_in_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (!i_stat.is_tick) begin
                    n_state = S_IDLE;
                end else if (i_stat.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.load_interval = 1'b1;
                    n_state             = S_STEP;
                end
            end
            S_STEP: begin
                // hold while a result is due and the previous one is not taken
                if (!(i_stat.has_result && i_stat.out_busy)) begin
                    o_cmd.step_commit = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

endmodule

FILE: hw/rtl/led_dimmer_ramp_channel.sv
// LED dimmer ramp channel, top level: APB registers, sequencer and datapath.
// Commands pass accept and execute; a tick also passes the step state and the
// serial divider (one quotient bit a cycle) when the step interval is computed.
// One request at a time; a pending result does not block commands.
// Synchronous active-low reset: level 0, idle, day mode, registers to defaults.
// Depends on ldr_pkg, ldr_in_if, ldr_out_if, ldr_cfg_regs, ldr_ctrl, ldr_dpath.
module led_dimmer_ramp_channel import ldr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ldr_in_if.sink              i_in,
    ldr_out_if.source           o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [CfgDataW-1:0] pwdata,
    output logic [CfgDataW-1:0] prdata,
    output logic                pready
);

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign i_in.ready = in_ready;

    ldr_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ldr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    ldr_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_operation     (i_in.operation),
        .i_switch_on     (i_in.switch_on),
        .i_level         (i_in.level),
        .i_direction     (i_in.direction),
        .i_step_code     (i_in.step_code),
        .i_night         (i_in.night),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_report_kind   (o_out.report_kind),
        .o_current_level (o_out.current_level),
        .o_is_on         (o_out.is_on),
        .o_on_changed    (o_out.on_changed)
    );

endmodule
